// ===== rtl/core/sdcmd_pkg.sv =====
// shared types and constants for the sd spi command engine
package sdcmd_pkg;

    localparam int unsigned BLOCK_WITH_CRC = 514;

    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_INIT  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_BYTE3 = 2'd3
    } command_t;

    typedef enum logic [2:0] {
        CFG_READY_TIMEOUT  = 3'd0,
        CFG_RESPONSE_TRIES = 3'd1,
        CFG_INIT_TRIES     = 3'd2,
        CFG_TOKEN_TIMEOUT  = 3'd3,
        CFG_DUMMY_CLOCKS   = 3'd4
    } cfg_index_t;

    typedef enum logic [3:0] {
        PH_IDLE, PH_DUMMY, PH_RDY_DISCARD, PH_RDY_POLL, PH_FRAME,
        PH_RESP, PH_TRAIL, PH_TOKEN, PH_DATA
    } phase_t;

    typedef enum logic [3:0] {
        RT_NONE, RT_CMD0, RT_CMD8, RT_A41V2, RT_CMD58, RT_PROBE,
        RT_LOOP1, RT_CMD16, RT_CMD17
    } ret_t;

    localparam logic [7:0] C_CMD0   = 8'h40;
    localparam logic [7:0] C_CMD1   = 8'h41;
    localparam logic [7:0] C_CMD8   = 8'h48;
    localparam logic [7:0] C_CMD16  = 8'h50;
    localparam logic [7:0] C_CMD17  = 8'h51;
    localparam logic [7:0] C_CMD55  = 8'h77;
    localparam logic [7:0] C_CMD58  = 8'h7A;
    localparam logic [7:0] C_ACMD41 = 8'hE9;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RD_ERR  = 2'd1;
    localparam logic [1:0] ST_NO_INIT = 2'd2;

endpackage

// ===== rtl/core/sd_spi_card_command_engine.sv =====
// each result is registered in the cycle after its request is taken and held in an output register
// throughput: one request per cycle; a new request waits while an unread result is held
// a request advances one step of the card sequencer; no loops over cycles
// reset: synchronous active low aresetn, sequencer idle, no card, configuration registers at defaults
// the user must write configuration only while idle; the block itself does not enforce this
module sd_spi_card_command_engine
    import sdcmd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [7:0]  s_rx_byte,
    input  logic [31:0] s_sector,
    input  logic [9:0]  s_offset,
    input  logic [9:0]  s_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_tx_byte,
    output logic        m_select_low,
    output logic [7:0]  m_data_byte,
    output logic        m_data_valid,
    output logic        m_done_res,
    output logic [1:0]  m_status,
    output logic [2:0]  m_card_kind
);

    logic [15:0] ready_timeout_reg, init_tries_reg, token_timeout_reg;
    logic [7:0]  response_tries_reg, dummy_clocks_reg;

    phase_t      phase_reg, phase_next;
    ret_t        ret_reg, ret_next;
    logic [15:0] poll_reg, poll_next, retry_reg, retry_next;
    logic [2:0]  fidx_reg, fidx_next;
    logic [7:0]  cidx_reg, cidx_next;
    logic [31:0] carg_reg, carg_next, ocr_reg, ocr_next;
    logic [2:0]  ctype_reg, ctype_next;
    logic [9:0]  bpos_reg, bpos_next, skip_reg, skip_next, dlv_reg, dlv_next;

    logic [7:0] o_tx;
    logic       o_sel, o_dv, o_done;
    logic [7:0] o_db;
    logic [1:0] o_st;

    logic accept;
    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid || m_ready;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_timeout_reg  <= 16'd2500;
            response_tries_reg <= 8'd10;
            init_tries_reg     <= 16'd25000;
            token_timeout_reg  <= 16'd1000;
            dummy_clocks_reg   <= 8'd50;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_READY_TIMEOUT:  ready_timeout_reg  <= cfg_data;
                CFG_RESPONSE_TRIES: response_tries_reg <= cfg_data[7:0];
                CFG_INIT_TRIES:     init_tries_reg     <= cfg_data;
                CFG_TOKEN_TIMEOUT:  token_timeout_reg  <= cfg_data;
                CFG_DUMMY_CLOCKS:   dummy_clocks_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    function automatic logic [15:0] at1(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    always_comb begin
        logic        pre;
        logic [7:0]  c;
        logic [31:0] a;
        logic [2:0]  fi;
        logic [7:0]  res;
        logic        do_complete, do_resume, do_loop1, do_trail;
        logic [15:0] rdec;
        logic [9:0]  skip_sat, room;
        logic [31:0] ocr_sh;
        phase_next = phase_reg; ret_next = ret_reg; poll_next = poll_reg;
        retry_next = retry_reg; fidx_next = fidx_reg; cidx_next = cidx_reg;
        carg_next = carg_reg; ocr_next = ocr_reg; ctype_next = ctype_reg;
        bpos_next = bpos_reg; skip_next = skip_reg; dlv_next = dlv_reg;
        o_tx = 8'hFF; o_sel = 1'b0; o_db = 8'h00; o_dv = 1'b0; o_done = 1'b0;
        o_st = ST_OK;
        do_complete = 1'b0; do_resume = 1'b0; do_loop1 = 1'b0; do_trail = 1'b0;
        res = s_rx_byte;
        rdec = retry_reg;
        fi = fidx_reg + 3'd1;
        pre = cidx_reg[7];
        c = pre ? C_CMD55 : cidx_reg;
        a = pre ? 32'd0 : carg_reg;
        skip_sat = (s_offset > 10'(BLOCK_WITH_CRC)) ? 10'(BLOCK_WITH_CRC) : s_offset;
        room = 10'(BLOCK_WITH_CRC) - skip_sat;
        ocr_sh = {ocr_reg[23:0], s_rx_byte};
        case (s_command)
            CMD_INIT: begin
                ctype_next = 3'd0;
                poll_next = at1({8'd0, dummy_clocks_reg});
                phase_next = PH_DUMMY;
            end
            CMD_READ: begin
                if (ctype_reg == 3'd0) begin
                    phase_next = PH_IDLE; o_done = 1'b1; o_st = ST_NO_INIT;
                end else begin
                    skip_next = skip_sat;
                    dlv_next = (s_count > room) ? room : s_count;
                    cidx_next = C_CMD17; carg_next = s_sector; ret_next = RT_CMD17;
                    phase_next = PH_RDY_DISCARD; o_sel = 1'b1;
                end
            end
            default: begin
                case (phase_reg)
                    PH_DUMMY: begin
                        if (poll_reg <= 16'd1) begin
                            cidx_next = C_CMD0; carg_next = '0; ret_next = RT_CMD0;
                            phase_next = PH_RDY_DISCARD; o_sel = 1'b1;
                        end else poll_next = poll_reg - 16'd1;
                    end
                    PH_RDY_DISCARD: begin
                        phase_next = PH_RDY_POLL; poll_next = at1(ready_timeout_reg);
                        o_sel = 1'b1;
                    end
                    PH_RDY_POLL: begin
                        if (s_rx_byte == 8'hFF) begin
                            phase_next = PH_FRAME; fidx_next = 3'd0; o_tx = c; o_sel = 1'b1;
                        end else if (poll_reg <= 16'd1) begin
                            do_complete = 1'b1; res = 8'hFF;
                        end else begin
                            poll_next = poll_reg - 16'd1; o_sel = 1'b1;
                        end
                    end
                    PH_FRAME: begin
                        fidx_next = fi; o_sel = 1'b1;
                        case (fi)
                            3'd1: o_tx = a[31:24];
                            3'd2: o_tx = a[23:16];
                            3'd3: o_tx = a[15:8];
                            3'd4: o_tx = a[7:0];
                            3'd5: o_tx = (c == C_CMD0) ? 8'h95 :
                                         (c == C_CMD8) ? 8'h87 : 8'h01;
                            default: begin
                                o_tx = 8'hFF; phase_next = PH_RESP;
                                poll_next = at1({8'd0, response_tries_reg});
                            end
                        endcase
                    end
                    PH_RESP: begin
                        if (!s_rx_byte[7] || poll_reg <= 16'd1) do_complete = 1'b1;
                        else begin
                            poll_next = poll_reg - 16'd1; o_sel = 1'b1;
                        end
                    end
                    PH_TRAIL: begin
                        ocr_next = ocr_sh; fidx_next = fi;
                        if (fi < 3'd4) o_sel = 1'b1;
                        else do_trail = 1'b1;
                    end
                    PH_TOKEN: begin
                        if (s_rx_byte == 8'hFE) begin
                            phase_next = PH_DATA; bpos_next = '0; o_sel = 1'b1;
                        end else if (s_rx_byte != 8'hFF || poll_reg <= 16'd1) begin
                            phase_next = PH_IDLE; o_done = 1'b1; o_st = ST_RD_ERR;
                        end else begin
                            poll_next = poll_reg - 16'd1; o_sel = 1'b1;
                        end
                    end
                    PH_DATA: begin
                        bpos_next = bpos_reg + 10'd1;
                        if (skip_reg != 10'd0) skip_next = skip_reg - 10'd1;
                        else if (dlv_reg != 10'd0) begin
                            dlv_next = dlv_reg - 10'd1; o_db = s_rx_byte; o_dv = 1'b1;
                        end
                        if (bpos_next >= 10'(BLOCK_WITH_CRC)) begin
                            phase_next = PH_IDLE; o_done = 1'b1;
                        end else o_sel = 1'b1;
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        endcase

        if (do_complete) begin
            if (pre && res <= 8'd1) begin
                cidx_next = {1'b0, cidx_reg[6:0]}; phase_next = PH_RDY_DISCARD;
                o_sel = 1'b1;
            end else do_resume = 1'b1;
        end

        if (do_trail) begin
            if (ret_reg == RT_CMD8) begin
                if (ocr_sh[15:8] == 8'h01 && ocr_sh[7:0] == 8'hAA) begin
                    retry_next = init_tries_reg;
                    if (init_tries_reg == 16'd0) begin
                        ctype_next = 3'd0; phase_next = PH_IDLE; o_done = 1'b1;
                        o_st = ST_NO_INIT;
                    end else begin
                        cidx_next = C_ACMD41; carg_next = 32'h4000_0000;
                        ret_next = RT_A41V2; phase_next = PH_RDY_DISCARD; o_sel = 1'b1;
                    end
                end else begin
                    ctype_next = 3'd0; phase_next = PH_IDLE; o_done = 1'b1;
                    o_st = ST_NO_INIT;
                end
            end else begin
                ctype_next = ocr_sh[30] ? 3'd4 : 3'd3; phase_next = PH_IDLE;
                o_done = 1'b1;
            end
        end

        if (do_resume) begin
            case (ret_reg)
                RT_CMD0: begin
                    if (res == 8'd1) begin
                        cidx_next = C_CMD8; carg_next = 32'h1AA; ret_next = RT_CMD8;
                        phase_next = PH_RDY_DISCARD; o_sel = 1'b1;
                    end else begin
                        ctype_next = 3'd0; phase_next = PH_IDLE; o_done = 1'b1;
                        o_st = ST_NO_INIT;
                    end
                end
                RT_CMD8: begin
                    if (res == 8'd1) begin
                        phase_next = PH_TRAIL; fidx_next = '0; ocr_next = '0;
                        o_sel = 1'b1;
                    end else begin
                        cidx_next = C_ACMD41; carg_next = '0; ret_next = RT_PROBE;
                        phase_next = PH_RDY_DISCARD; o_sel = 1'b1;
                    end
                end
                RT_A41V2: begin
                    if (res == 8'd0) begin
                        cidx_next = C_CMD58; carg_next = '0; ret_next = RT_CMD58;
                        phase_next = PH_RDY_DISCARD; o_sel = 1'b1;
                    end else begin
                        rdec = (retry_reg != 16'd0) ? retry_reg - 16'd1 : retry_reg;
                        retry_next = rdec;
                        if (rdec == 16'd0) begin
                            ctype_next = 3'd0; phase_next = PH_IDLE; o_done = 1'b1;
                            o_st = ST_NO_INIT;
                        end else begin
                            cidx_next = C_ACMD41; carg_next = 32'h4000_0000;
                            ret_next = RT_A41V2; phase_next = PH_RDY_DISCARD;
                            o_sel = 1'b1;
                        end
                    end
                end
                RT_CMD58: begin
                    if (res == 8'd0) begin
                        phase_next = PH_TRAIL; fidx_next = '0; ocr_next = '0;
                        o_sel = 1'b1;
                    end else begin
                        ctype_next = 3'd0; phase_next = PH_IDLE; o_done = 1'b1;
                        o_st = ST_NO_INIT;
                    end
                end
                RT_PROBE: begin
                    ocr_next = (res <= 8'd1) ? 32'd2 : 32'd1;
                    rdec = init_tries_reg; retry_next = rdec; do_loop1 = 1'b1;
                end
                RT_LOOP1: begin
                    if (res == 8'd0) begin
                        cidx_next = C_CMD16; carg_next = 32'd512; ret_next = RT_CMD16;
                        phase_next = PH_RDY_DISCARD; o_sel = 1'b1;
                    end else begin
                        rdec = (retry_reg != 16'd0) ? retry_reg - 16'd1 : retry_reg;
                        retry_next = rdec; do_loop1 = 1'b1;
                    end
                end
                RT_CMD16: begin
                    if (res == 8'd0) ctype_next = ocr_reg[2:0];
                    else begin
                        ctype_next = 3'd0; o_st = ST_NO_INIT;
                    end
                    phase_next = PH_IDLE; o_done = 1'b1;
                end
                RT_CMD17: begin
                    if (res == 8'd0) begin
                        phase_next = PH_TOKEN; poll_next = at1(token_timeout_reg);
                        o_sel = 1'b1;
                    end else begin
                        phase_next = PH_IDLE; o_done = 1'b1; o_st = ST_RD_ERR;
                    end
                end
                default: begin
                    phase_next = PH_IDLE; o_done = 1'b1;
                end
            endcase
        end

        if (do_loop1) begin
            if (rdec == 16'd0) begin
                ctype_next = 3'd0; phase_next = PH_IDLE; o_done = 1'b1;
                o_st = ST_NO_INIT;
            end else begin
                cidx_next = (ocr_next == 32'd2) ? C_ACMD41 : C_CMD1; carg_next = '0;
                ret_next = RT_LOOP1; phase_next = PH_RDY_DISCARD; o_sel = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE; ret_reg <= RT_NONE; poll_reg <= '0; retry_reg <= '0;
            fidx_reg <= '0; cidx_reg <= '0; carg_reg <= '0; ocr_reg <= '0;
            ctype_reg <= '0; bpos_reg <= '0; skip_reg <= '0; dlv_reg <= '0;
            m_valid <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next; ret_reg <= ret_next; poll_reg <= poll_next;
                retry_reg <= retry_next; fidx_reg <= fidx_next; cidx_reg <= cidx_next;
                carg_reg <= carg_next; ocr_reg <= ocr_next; ctype_reg <= ctype_next;
                bpos_reg <= bpos_next; skip_reg <= skip_next; dlv_reg <= dlv_next;
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tx_byte <= o_tx; m_select_low <= o_sel; m_data_byte <= o_db;
            m_data_valid <= o_dv; m_done_res <= o_done; m_status <= o_st;
            m_card_kind <= ctype_next;
        end
    end

    a_done_deselect: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_select_low && m_tx_byte == 8'hFF)
        else $error("done result without release byte");
    a_idle_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && o_done |=> phase_reg == PH_IDLE)
        else $error("sequencer not idle after done");
    a_data_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && o_dv |-> phase_reg == PH_DATA)
        else $error("data delivered outside block read");

endmodule
